/* rtl/core/mts_pkg.sv */
// Shared types and constants for the min-tracking stack.
// No dependencies; imported by mts_store and min_tracking_stack_top.
`default_nettype none

package mts_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned DepthW = 7;

  // operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_POP_WAIT
  } state_e;

  // one stored entry: pushed value and minimum of it and everything below
  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic signed [DataW-1:0] minimum;
  } entry_t;

endpackage

`default_nettype wire

/* rtl/core/min_tracking_stack_top.sv */
// Top level of the min-tracking stack: control, top-of-stack registers, result registers.
// Depends on mts_pkg and mts_store.
//
// Usage:
//   Command channel: drive operation_i (push or pop) and value_i with start_i high;
//   the transaction is taken at a rising edge where start_i is high and busy_o is low.
//   Result channel: done_o is high for exactly one cycle with top_value_o,
//   min_value_o, depth_o, is_empty_o and status_o. The receiver cannot stall;
//   the result must be captured in that cycle.
//   Completion: a push, a refused push/pop, and a pop that leaves the
//   stack empty finish directly (result the cycle after acceptance, next command
//   may follow right away). A pop that leaves entries behind also passes through
//   S_POP_WAIT: the new top lies in the entry memory, whose read port is registered,
//   and busy_o is high during the wait.
//   The top entry lives in registers; the memory holds the entries below it, so a
//   push writes the old top and never needs a read.
//   Reset (rst_ni low, asynchronous) empties the stack and clears done_o and
//   busy_o. Memory contents are not cleared; entries at or above the depth are
//   never read.
//   Overflow: a push onto a full stack is refused, status reports overflow and
//   the other fields show the unchanged stack. Underflow: a pop on an empty stack
//   is refused and reports an empty stack with underflow status.
`default_nettype none

module min_tracking_stack_top
  import mts_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  output logic                         busy_o,
  input  wire logic                    operation_i,
  input  wire logic signed [DataW-1:0] value_i,
  output logic                         done_o,
  output logic signed [DataW-1:0]      top_value_o,
  output logic signed [DataW-1:0]      min_value_o,
  output logic [DepthW-1:0]            depth_o,
  output logic                         is_empty_o,
  output logic [1:0]                   status_o
);

  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(DEPTH + 1);

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic signed [DataW-1:0] top_q, top_d;
  logic signed [DataW-1:0] min_q, min_d;

  // result registers
  logic                    done_q, done_d;
  logic signed [DataW-1:0] rtop_q, rtop_d;
  logic signed [DataW-1:0] rmin_q, rmin_d;
  logic [CntW-1:0]         rcnt_q, rcnt_d;
  logic [1:0]              rst_q, rst_d;

  // memory port
  logic             we, re;
  logic [AddrW-1:0] waddr, raddr;
  entry_t           wdata, rdata;

  logic signed [DataW-1:0] push_min;
  logic                    full;

  mts_store #(
    .AddrW(AddrW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign full  = (cnt_q == CntW'(DEPTH));
  // old top goes to the slot just below the new top
  assign waddr = AddrW'(cnt_q - CntW'(1));
  // the entry below the current top becomes the new top on a pop
  assign raddr = AddrW'(cnt_q - CntW'(2));
  assign wdata = '{value: top_q, minimum: min_q};
  assign push_min = ((cnt_q != '0) && (min_q < value_i)) ? min_q : value_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    top_d   = top_q;
    min_d   = min_q;
    done_d  = 1'b0;
    rtop_d  = rtop_q;
    rmin_d  = rmin_q;
    rcnt_d  = rcnt_q;
    rst_d   = rst_q;
    we      = 1'b0;
    re      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (operation_i == OP_PUSH) begin
            done_d = 1'b1;
            if (full) begin
              // refuse, report the unchanged stack
              rtop_d = top_q;
              rmin_d = min_q;
              rcnt_d = cnt_q;
              rst_d  = ST_OVERFLOW;
            end else begin
              we     = (cnt_q != '0);
              top_d  = value_i;
              min_d  = push_min;
              cnt_d  = cnt_q + CntW'(1);
              rtop_d = value_i;
              rmin_d = push_min;
              rcnt_d = cnt_q + CntW'(1);
              rst_d  = ST_OK;
            end
          end else begin
            if (cnt_q == '0) begin
              done_d = 1'b1;
              rtop_d = '0;
              rmin_d = '0;
              rcnt_d = '0;
              rst_d  = ST_UNDERFLOW;
            end else if (cnt_q == CntW'(1)) begin
              // drop the last entry, stack goes empty
              done_d = 1'b1;
              cnt_d  = '0;
              rtop_d = '0;
              rmin_d = '0;
              rcnt_d = '0;
              rst_d  = ST_OK;
            end else begin
              re      = 1'b1;
              state_d = S_POP_WAIT;
            end
          end
        end
      end
      S_POP_WAIT: begin
        // load the new top from memory
        top_d   = rdata.value;
        min_d   = rdata.minimum;
        cnt_d   = cnt_q - CntW'(1);
        done_d  = 1'b1;
        rtop_d  = rdata.value;
        rmin_d  = rdata.minimum;
        rcnt_d  = cnt_q - CntW'(1);
        rst_d   = ST_OK;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q  <= top_d;
    min_q  <= min_d;
    rtop_q <= rtop_d;
    rmin_q <= rmin_d;
    rcnt_q <= rcnt_d;
    rst_q  <= rst_d;
  end

  assign busy_o      = (state_q == S_POP_WAIT);
  assign done_o      = done_q;
  assign top_value_o = rtop_q;
  assign min_value_o = rmin_q;
  assign depth_o     = DepthW'(rcnt_q);
  assign is_empty_o  = (rcnt_q == '0);
  assign status_o    = rst_q;

endmodule

`default_nettype wire

/* rtl/core/mts_store.sv */
// Entry memory of the min-tracking stack: one write port, one registered read port.
// Depends on mts_pkg for the entry type.
`default_nettype none

module mts_store
  import mts_pkg::*;
#(
  parameter int unsigned AddrW = 6
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire entry_t           wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output entry_t                rdata_o
);

  entry_t mem_q [2**AddrW];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* dv/min_tracking_stack_top_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for min_tracking_stack_top: push/pop transactions, results
// checked field by field against a behavioral stack that tracks the running minimum.
// Depends on mts_pkg and the min_tracking_stack_top RTL.

module min_tracking_stack_top_tb;
  import mts_pkg::*;

  localparam int StackDepth = 64;

  // one pushed or popped transaction; hold_for_drain pauses the sender until all
  // outstanding results have come back
  typedef struct {
    logic                    op;
    logic signed [DataW-1:0] value;
    bit                      hold_for_drain;
  } stack_cmd_t;

  typedef struct {
    logic signed [DataW-1:0] top;
    logic signed [DataW-1:0] minimum;
    logic [DepthW-1:0]       depth;
    logic                    empty;
    logic [1:0]              status;
  } stack_view_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start_i = 1'b0;
  logic                    operation_i = OP_PUSH;
  logic signed [DataW-1:0] value_i = '0;
  logic                    busy_o;
  logic                    done_o;
  logic signed [DataW-1:0] top_value_o;
  logic signed [DataW-1:0] min_value_o;
  logic [DepthW-1:0]       depth_o;
  logic                    is_empty_o;
  logic [1:0]              status_o;

  min_tracking_stack_top #(
    .DEPTH(StackDepth)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .operation_i(operation_i),
    .value_i    (value_i),
    .done_o     (done_o),
    .top_value_o(top_value_o),
    .min_value_o(min_value_o),
    .depth_o    (depth_o),
    .is_empty_o (is_empty_o),
    .status_o   (status_o)
  );

  // 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  stack_cmd_t  pending_cmds[$];
  stack_view_t views_due[$];
  int          mismatch_count = 0;

  // Behavioral stack: value and running minimum per entry, plus the entry count.
  logic signed [DataW-1:0] shadow_value[StackDepth];
  logic signed [DataW-1:0] shadow_min[StackDepth];
  int                      shadow_count = 0;

  // Sender idling state
  int gap_left = 0;
  int idle_free_left = 0;

  // Stimulus generator bookkeeping: depth the generated sequence reaches
  int gen_depth = 0;

  task automatic log_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      log_mismatch($sformatf("%s got %08h expected %08h", name, got, want));
  endtask

  // Apply one accepted transaction to the shadow stack and queue the view it yields.
  task automatic apply_stack_op(input logic op, input logic signed [DataW-1:0] val);
    stack_view_t v;
    logic signed [DataW-1:0] run_min;
    v.status = ST_OK;
    if (op == OP_PUSH) begin
      if (shadow_count >= StackDepth) begin
        v.status = ST_OVERFLOW;
      end else begin
        run_min = val;
        // keep the smaller of the new value and the minimum below it
        if (shadow_count > 0 && shadow_min[shadow_count-1] < val)
          run_min = shadow_min[shadow_count-1];
        shadow_value[shadow_count] = val;
        shadow_min[shadow_count]   = run_min;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) v.status = ST_UNDERFLOW;
      else shadow_count--;
    end
    v.top     = (shadow_count > 0) ? shadow_value[shadow_count-1] : '0;
    v.minimum = (shadow_count > 0) ? shadow_min[shadow_count-1] : '0;
    v.depth   = shadow_count[DepthW-1:0];
    v.empty   = (shadow_count == 0);
    views_due.push_back(v);
  endtask

  // Mostly short gaps, a few long ones, and now and then a run with no idling.
  function automatic int draw_gap();
    int r;
    if (idle_free_left > 0) begin
      idle_free_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      idle_free_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Value mix: full-range words, a narrow band around zero so minima repeat
  // and tie, and the signed extremes.
  function automatic logic signed [DataW-1:0] draw_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom;
      5, 6, 7:       return $signed($urandom_range(0, 16)) - 8;
      8:             return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default:       return $urandom_range(0, 1) ? -32'sd1 : 32'sd0;
    endcase
  endfunction

  task automatic add_cmd(input logic op, input logic signed [DataW-1:0] val,
                         input bit hold = 1'b0);
    stack_cmd_t c;
    c.op = op;
    c.value = val;
    c.hold_for_drain = hold;
    pending_cmds.push_back(c);
    if (op == OP_PUSH && gen_depth < StackDepth) gen_depth++;
    if (op == OP_POP && gen_depth > 0) gen_depth--;
  endtask

  // A transaction is taken at a rising edge with start high and busy low; register
  // that so the driver sees it at the following falling edge.
  logic taken_q;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q <= 1'b0;
    end else begin
      taken_q <= start_i && !busy_o;
    end
  end

  // Driver: runs on the falling edge. Predict the transaction just taken, then
  // either hold the current one, idle, or present the next pending one. start_i
  // gets exactly one assignment per edge so back-to-back transactions keep it high.
  always @(negedge clk_i) begin
    logic start_nx;
    stack_cmd_t cmd;
    if (rst_ni) begin
      start_nx = start_i;
      if (taken_q) begin
        apply_stack_op(operation_i, value_i);
        start_nx = 1'b0;
        gap_left = draw_gap();
      end
      if (!start_nx) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds.size() > 0 &&
                     !(pending_cmds[0].hold_for_drain && views_due.size() > 0)) begin
          cmd = pending_cmds.pop_front();
          start_nx = 1'b1;
          operation_i <= cmd.op;
          value_i <= cmd.value;
        end
      end
      start_i <= start_nx;
    end
  end

  // Monitor: results are valid for one cycle only, so sample at every rising edge
  // and compare against the oldest outstanding view.
  always @(posedge clk_i) begin
    stack_view_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (views_due.size() == 0) begin
        log_mismatch("result with no transaction outstanding");
      end else begin
        want = views_due.pop_front();
        check_field("top_value", top_value_o, want.top);
        check_field("min_value", min_value_o, want.minimum);
        check_field("depth", {25'd0, depth_o}, {25'd0, want.depth});
        check_field("is_empty", {31'd0, is_empty_o}, {31'd0, want.empty});
        check_field("status", {30'd0, status_o}, {30'd0, want.status});
      end
    end
  end

  // Stimulus and end of test
  initial begin
    int  n_random;
    int  seg_len;
    int  push_pct;
    logic op;

    // Directed: underflow on empty, signed extremes, ties, min restored on pop,
    // pop that empties the stack, pop that leaves entries behind.
    add_cmd(OP_POP, 32'sh1234_5678);
    add_cmd(OP_PUSH, 32'sh7fff_ffff);
    add_cmd(OP_PUSH, 32'sh8000_0000);
    add_cmd(OP_PUSH, -32'sd1);
    add_cmd(OP_PUSH, 32'sd0);
    add_cmd(OP_POP, 32'sd0);
    add_cmd(OP_POP, -32'sd1);
    add_cmd(OP_POP, 32'sh7fff_ffff);
    add_cmd(OP_POP, 32'sd0);
    add_cmd(OP_POP, 32'sd0);
    add_cmd(OP_PUSH, 32'sd5);
    add_cmd(OP_PUSH, 32'sd5);
    add_cmd(OP_PUSH, 32'sd3);
    add_cmd(OP_PUSH, 32'sd7);
    add_cmd(OP_PUSH, -32'sd2);
    add_cmd(OP_POP, 32'sd0);
    add_cmd(OP_POP, 32'sd0);
    add_cmd(OP_POP, 32'sd0);
    add_cmd(OP_POP, 32'sd0);
    add_cmd(OP_POP, 32'sd0);
    add_cmd(OP_PUSH, 32'sh5555_5555);
    add_cmd(OP_PUSH, 32'shaaaa_aaaa);
    add_cmd(OP_POP, 32'sd0);
    add_cmd(OP_POP, 32'sd0);

    // Fill to the top, run into overflow, then drain past empty into underflow.
    // The first of these waits for the directed results to drain.
    n_random = 0;
    add_cmd(OP_PUSH, draw_value(), 1'b1);
    n_random++;
    while (gen_depth < StackDepth) begin
      add_cmd(OP_PUSH, draw_value());
      n_random++;
    end
    repeat (3) begin
      add_cmd(OP_PUSH, draw_value());
      n_random++;
    end
    while (gen_depth > 0) begin
      add_cmd(OP_POP, draw_value());
      n_random++;
    end
    add_cmd(OP_POP, draw_value());
    n_random++;

    // Random walks: push-heavy, pop-heavy and balanced segments so the depth
    // sweeps the whole range and both boundaries are hit repeatedly.
    while (n_random < 550) begin
      seg_len = $urandom_range(20, 80);
      case ($urandom_range(0, 2))
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
      repeat (seg_len) begin
        op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
        add_cmd(op, draw_value(), $urandom_range(0, 99) < 2);
        n_random++;
      end
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Every transaction taken and every result back, then let the pipeline settle.
    while (pending_cmds.size() != 0 || start_i || views_due.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (views_due.size() != 0) log_mismatch("expected results never arrived");

    if (mismatch_count == 0) begin
      $display("[min_tracking_stack_top] OK");
    end else begin
      $display("[min_tracking_stack_top] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("[min_tracking_stack_top] ERROR");
    $finish;
  end

endmodule
